FILE: rtl/core/assert_macros.svh
// Assertion macros used by the framebuffer top level in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is active.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/core/sxf_pkg.sv
`default_nettype none

package sxf_pkg;

    // Screen geometry
    localparam int SCREEN_COLS = 64;
    localparam int SCREEN_ROWS = 32;
    localparam int COL_AW      = $clog2(SCREEN_COLS);
    localparam int ROW_AW      = $clog2(SCREEN_ROWS);
    localparam int SPRITE_W    = 8;

    // Item kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Input beat
    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          start_x;
        logic [7:0]          start_y;
        logic [3:0]          row_offset;
        logic [SPRITE_W-1:0] sprite_row;
        logic                last_row;
        logic [4:0]          read_row;
    } item_t;

    // Result beat
    typedef struct packed {
        logic                   collision;
        logic                   sprite_done;
        logic [SCREEN_COLS-1:0] row_pixels;
    } result_t;

    // Row store update from the execute stage
    typedef struct packed {
        logic                   wr_en;
        logic                   clr;
        logic [ROW_AW-1:0]      addr;
        logic [SCREEN_COLS-1:0] data;
    } mem_wr_t;

    // Target row of a draw: masked y plus offset, bit ROW_AW set means off screen
    function automatic logic [ROW_AW:0] draw_row(input logic [7:0] start_y,
                                                 input logic [3:0] row_offset);
        logic [ROW_AW:0] y;
        y = {1'b0, start_y[ROW_AW-1:0]} + {{(ROW_AW-3){1'b0}}, row_offset};
        return y;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sxf_rowmem.sv
`default_nettype none

// Screen row store: one write and one registered read per cycle.
// Per-row valid bits make reset and the clear item take effect at once.
module sxf_rowmem (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             rd_en,
    input  wire logic [sxf_pkg::ROW_AW-1:0]       rd_addr,
    input  wire sxf_pkg::mem_wr_t                 wr,
    output logic      [sxf_pkg::SCREEN_COLS-1:0]  rd_data
);

    logic [sxf_pkg::SCREEN_COLS-1:0] mem_reg [sxf_pkg::SCREEN_ROWS];
    logic [sxf_pkg::SCREEN_COLS-1:0] rd_data_reg;
    logic [sxf_pkg::SCREEN_ROWS-1:0] vld_reg;
    logic                            rd_vld_reg;

    // Data array, no reset
    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // Row valid bits; an invalid row reads as blank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (wr.clr)
            begin
                vld_reg <= '0;
            end
            else if (wr.wr_en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/core/sxf_exec.sv
`default_nettype none

// Execute stage: clear the screen, XOR a sprite row into the old row word and
// track collision, or pass a read row on; form the result beat and register it.
module sxf_exec (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            vld,
    input  wire sxf_pkg::item_t                  item,
    input  wire logic [sxf_pkg::SCREEN_COLS-1:0] old_row,
    output sxf_pkg::mem_wr_t                     wr,
    output logic                                 done,
    output sxf_pkg::result_t                     result
);

    logic                            hit_reg;
    logic                            hit_next;
    logic                            done_reg;
    sxf_pkg::result_t                result_reg;
    sxf_pkg::result_t                result_next;
    logic [sxf_pkg::ROW_AW:0]        y;
    logic                            on_screen;
    logic [sxf_pkg::SPRITE_W-1:0]    rev_bits;
    logic [sxf_pkg::SCREEN_COLS-1:0] mask;

    // Sprite mask: bit 7 lands at column x, shifted-out columns are clipped
    always_comb
    begin
        for (int n = 0; n < sxf_pkg::SPRITE_W; n++)
        begin
            rev_bits[n] = item.sprite_row[sxf_pkg::SPRITE_W-1-n];
        end
        mask = sxf_pkg::SCREEN_COLS'(rev_bits) << item.start_x[sxf_pkg::COL_AW-1:0];
    end

    assign y         = sxf_pkg::draw_row(item.start_y, item.row_offset);
    assign on_screen = ~y[sxf_pkg::ROW_AW];

    // Per-kind update
    always_comb
    begin
        hit_next    = hit_reg;
        wr.wr_en    = 1'b0;
        wr.clr      = 1'b0;
        wr.addr     = y[sxf_pkg::ROW_AW-1:0];
        wr.data     = old_row ^ mask;
        result_next = '0;
        unique case (item.kind)
            sxf_pkg::KIND_CLEAR:
            begin
                wr.clr = vld;
            end
            sxf_pkg::KIND_DRAW:
            begin
                if (item.row_offset == 4'd0)
                begin
                    hit_next = 1'b0;
                end
                if (on_screen)
                begin
                    wr.wr_en = vld;
                    if ((old_row & mask) != '0)
                    begin
                        hit_next = 1'b1;
                    end
                end
                result_next.sprite_done = item.last_row;
            end
            sxf_pkg::KIND_READ:
            begin
                result_next.row_pixels = old_row;
            end
            default:
            begin
                // unused kind: no state change
            end
        endcase
        result_next.collision = hit_next;
    end

    // Collision flag and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld;
            if (vld)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sprite_xor_framebuffer.sv
`default_nettype none

// 64x32 monochrome framebuffer with XOR sprite rows and collision flag.
//
// Input: drive item and raise start; a beat is taken at each rising edge
// with start high and busy low. busy stays low, so a beat can be taken
// every cycle. Kinds: clear screen, draw one 8-pixel sprite row, read one
// 64-pixel screen row (column c at bit c).
//
// Output: every beat gives exactly one result beat, shown on result for
// one cycle with done high; the beat passes the registered row read, then
// the XOR and result register.
// Throughput is one beat per cycle; back-to-back beats on the same row are
// forwarded from the execute stage around the row store's read port.
// The receiver cannot stall: a result is gone after its cycle.
//
// Reset (rst_n, asynchronous, active low) blanks the screen at once via
// per-row valid bits and clears the collision flag; no clearing pass.
module sprite_xor_framebuffer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire sxf_pkg::item_t   item,
    output logic                  done,
    output sxf_pkg::result_t      result
);

`include "assert_macros.svh"

    logic                            accept;
    logic                            a_vld_reg;
    sxf_pkg::item_t                  a_item_reg;
    logic [sxf_pkg::ROW_AW:0]        y;
    logic [sxf_pkg::ROW_AW-1:0]      rd_addr;
    logic [sxf_pkg::SCREEN_COLS-1:0] mem_rd_data;
    logic [sxf_pkg::SCREEN_COLS-1:0] old_row;
    sxf_pkg::mem_wr_t                wr;
    logic                            fwd_clr_reg;
    logic                            fwd_wr_reg;
    logic [sxf_pkg::SCREEN_COLS-1:0] fwd_data_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Row to fetch for the incoming beat
    assign y       = sxf_pkg::draw_row(item.start_y, item.row_offset);
    assign rd_addr = (item.kind == sxf_pkg::KIND_READ) ? item.read_row
                                                       : y[sxf_pkg::ROW_AW-1:0];

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            fwd_clr_reg <= 1'b0;
            fwd_wr_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg   <= accept;
            // capture what the execute stage changes in the same edge
            fwd_clr_reg <= wr.clr;
            fwd_wr_reg  <= wr.wr_en && (wr.addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr.data;
        if (accept)
        begin
            a_item_reg <= item;
        end
    end

    sxf_rowmem u_rowmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_data (mem_rd_data)
    );

    // Old row with forwarding from the previous beat
    always_comb
    begin
        priority if (fwd_clr_reg)
        begin
            old_row = '0;
        end
        else if (fwd_wr_reg)
        begin
            old_row = fwd_data_reg;
        end
        else
        begin
            old_row = mem_rd_data;
        end
    end

    sxf_exec u_exec (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld     (a_vld_reg),
        .item    (a_item_reg),
        .old_row (old_row),
        .wr      (wr),
        .done    (done),
        .result  (result)
    );

    // Checks
    `ASSERT_CLK_RST(a_accept_gives_result, clk, rst_n,
        accept |-> ##2 done, "accepted beat did not produce a result")
    `ASSERT_CLK_RST(a_result_has_beat, clk, rst_n,
        done |-> $past(accept, 2), "result without an accepted beat")
    `ASSERT_CLK_RST(a_pixels_only_on_read, clk, rst_n,
        (done && (result.row_pixels != '0)) |-> $past(item.kind == sxf_pkg::KIND_READ, 2),
        "row pixels on a non-read beat")
    `ASSERT_CLK(a_no_write_when_idle, clk,
        !a_vld_reg |-> !(wr.wr_en || wr.clr), "row store changed with no beat in flight")

endmodule

`default_nettype wire

FILE: tb/sv/framebuffer_checker.sv
`timescale 1ns / 100ps

// Watches the item and result beats of the framebuffer, keeps its own copy of
// the screen and the collision flag, and compares every result beat in order.
module framebuffer_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire sxf_pkg::item_t   item,
    input  wire logic             done,
    input  wire sxf_pkg::result_t result,
    output int unsigned           fail_count,
    output int unsigned           pending_beats
);

    import sxf_pkg::*;

    localparam int MAX_COL = SCREEN_COLS - 1;
    localparam int MAX_ROW = SCREEN_ROWS - 1;

    // Shadow screen, column c at bit c, and the sprite collision flag
    logic [SCREEN_COLS-1:0] screen_img [SCREEN_ROWS];
    logic                   hit_flag;
    result_t                expected_results [$];

    // Apply one accepted item beat to the shadow state, return its result beat
    function automatic result_t apply_item(input item_t it);
        result_t                res;
        logic [SCREEN_COLS-1:0] mask;
        int                     col0;
        int                     row;
        res  = '0;
        mask = '0;
        col0 = int'(it.start_x) & MAX_COL;
        row  = (int'(it.start_y) & MAX_ROW) + int'(it.row_offset);
        case (it.kind)
            KIND_CLEAR:
            begin
                for (int r = 0; r < SCREEN_ROWS; r++)
                    screen_img[r] = '0;
            end
            KIND_DRAW:
            begin
                // new sprite starts with a clean collision flag
                if (it.row_offset == '0)
                    hit_flag = 1'b0;
                // rows below the screen are dropped whole
                if (row <= MAX_ROW)
                begin
                    // bit 7 is the leftmost pixel; columns past the edge are clipped
                    for (int n = 0; n < SPRITE_W; n++)
                        if (it.sprite_row[SPRITE_W-1-n] && (col0 + n) <= MAX_COL)
                            mask[col0+n] = 1'b1;
                    if ((screen_img[row] & mask) != '0)
                        hit_flag = 1'b1;
                    screen_img[row] ^= mask;
                end
                res.sprite_done = it.last_row;
            end
            KIND_READ:
            begin
                res.row_pixels = screen_img[it.read_row];
            end
            default:
            begin
                // unused kind: no state change, result as for a clear
            end
        endcase
        res.collision = hit_flag;
        return res;
    endfunction

    // Result beats are compared before the item beat of the same edge is queued
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < SCREEN_ROWS; r++)
                screen_img[r] = '0;
            hit_flag = 1'b0;
            expected_results.delete();
            fail_count    = 0;
            pending_beats = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: collision=%0b sprite_done=%0b row_pixels=%h",
                           result.collision, result.sprite_done, result.row_pixels);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.collision !== want.collision)
                    begin
                        $error("collision: expected %0b, got %0b",
                               want.collision, result.collision);
                        fail_count++;
                    end
                    if (result.sprite_done !== want.sprite_done)
                    begin
                        $error("sprite_done: expected %0b, got %0b",
                               want.sprite_done, result.sprite_done);
                        fail_count++;
                    end
                    if (result.row_pixels !== want.row_pixels)
                    begin
                        $error("row_pixels: expected %h, got %h",
                               want.row_pixels, result.row_pixels);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_item(item));
            pending_beats = expected_results.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import sxf_pkg::*;

    // Kind code the block leaves unused
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         PHASE_ITEMS  = 560;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    item_t       item;
    result_t     result;
    int unsigned fail_count;
    int unsigned pending_beats;
    int unsigned cycle_count = 0;
    int unsigned beats_sent  = 0;
    int          idle_pct;

    sprite_xor_framebuffer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    framebuffer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop for a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Every field random, any kind
    function automatic item_t random_item();
        item_t it;
        it.kind       = 2'($urandom_range(0, 3));
        it.start_x    = 8'($urandom);
        it.start_y    = 8'($urandom);
        it.row_offset = 4'($urandom);
        it.sprite_row = 8'($urandom);
        it.last_row   = 1'($urandom);
        it.read_row   = 5'($urandom);
        return it;
    endfunction

    // Unused fields stay random so the block is seen to ignore them
    function automatic item_t draw_item(input logic [7:0] x, input logic [7:0] y,
                                        input logic [3:0] off, input logic [7:0] bits,
                                        input logic last);
        item_t it;
        it            = random_item();
        it.kind       = KIND_DRAW;
        it.start_x    = x;
        it.start_y    = y;
        it.row_offset = off;
        it.sprite_row = bits;
        it.last_row   = last;
        return it;
    endfunction

    function automatic item_t read_item(input logic [4:0] row);
        item_t it;
        it          = random_item();
        it.kind     = KIND_READ;
        it.read_row = row;
        return it;
    endfunction

    function automatic item_t clear_item();
        item_t it;
        it      = random_item();
        it.kind = KIND_CLEAR;
        return it;
    endfunction

    // Idle at random, then hold the beat until it is taken
    task automatic send_beat(input item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            item  <= random_item();
            @(posedge clk);
        end
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
    endtask

    // Rows first .. first+rows-1 of one sprite with random pixels
    task automatic draw_sprite(input logic [7:0] x, input logic [7:0] y, input int first,
                               input int rows, input logic mark_last);
        for (int r = 0; r < rows; r++)
            send_beat(draw_item(x, y, 4'(first + r), 8'($urandom),
                                mark_last && (r == rows - 1)));
    endtask

    // Mostly whole sprites followed by reads of rows they touched
    task automatic run_random(input int count);
        int unsigned target;
        int          pick;
        int          rows;
        int          first;
        logic [7:0]  x;
        logic [7:0]  y;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            pick = $urandom_range(99);
            x    = 8'($urandom);
            y    = 8'($urandom);
            if (pick < 65)
            begin
                rows = $urandom_range(1, 16);
                draw_sprite(x, y, 0, rows, 1'b1);
                repeat ($urandom_range(1, 3))
                    send_beat(read_item(5'(y + $urandom_range(0, rows - 1))));
            end
            else if (pick < 75)
            begin
                // broken sprite: starts mid-way, last flag maybe missing
                first = $urandom_range(1, 15);
                rows  = $urandom_range(1, 16 - first);
                draw_sprite(x, y, first, rows, 1'($urandom));
            end
            else if (pick < 85)
            begin
                send_beat(random_item());
            end
            else if (pick < 96)
            begin
                repeat ($urandom_range(1, 4))
                    send_beat(read_item(5'($urandom)));
            end
            else
            begin
                send_beat(clear_item());
            end
        end
    endtask

    initial
    begin
        item_t odd_kind;
        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        idle_pct = 8;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // screen is blank after reset
        send_beat(read_item(5'd0));
        send_beat(read_item(5'd31));
        // full row at the left edge, then erase its end pixels: collision
        send_beat(draw_item(8'd0, 8'd0, 4'd0, 8'hFF, 1'b1));
        send_beat(read_item(5'd0));
        send_beat(draw_item(8'd0, 8'd0, 4'd0, 8'h81, 1'b1));
        // origin masked to the bottom right corner, only one pixel lands
        send_beat(draw_item(8'hFF, 8'hFF, 4'd0, 8'hFF, 1'b0));
        // next row falls below the screen
        send_beat(draw_item(8'hFF, 8'hFF, 4'd1, 8'hFF, 1'b1));
        send_beat(read_item(5'd31));
        // rightmost sprite pixel on the lit corner: collision
        send_beat(draw_item(8'd56, 8'd31, 4'd0, 8'h01, 1'b1));
        // clear keeps the collision flag, unused kind changes nothing
        send_beat(clear_item());
        send_beat(read_item(5'd31));
        odd_kind      = random_item();
        odd_kind.kind = KIND_UNUSED;
        send_beat(odd_kind);
        // clipped row with a nonzero offset keeps the flag
        send_beat(draw_item(8'd0, 8'd31, 4'd15, 8'hFF, 1'b1));
        // empty first row clears the flag
        send_beat(draw_item(8'd0, 8'd0, 4'd0, 8'h00, 1'b0));
        send_beat(draw_item(8'd0, 8'd17, 4'd15, 8'hFF, 1'b1));
        send_beat(draw_item(8'd0, 8'd16, 4'd15, 8'hFF, 1'b1));
        send_beat(read_item(5'd31));
        send_beat(draw_item(8'd7, 8'd5, 4'd3, 8'h80, 1'b1));
        send_beat(read_item(5'd8));
        send_beat(draw_item(8'd127, 8'd224, 4'd0, 8'hFF, 1'b1));
        send_beat(read_item(5'd0));
        send_beat(clear_item());
        send_beat(read_item(5'd31));

        // sender rarely idle, then mostly idle, then back to back
        run_random(PHASE_ITEMS);
        idle_pct = 84;
        run_random(PHASE_ITEMS);
        idle_pct = 0;
        run_random(PHASE_ITEMS);

        start <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
